### sv/servo_angle_to_pwm_level_assert.svh
// Assertion macros for the servo angle to PWM level block.
`ifndef SERVO_ANGLE_TO_PWM_LEVEL_ASSERT_SVH
`define SERVO_ANGLE_TO_PWM_LEVEL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SAPWM_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SAPWM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### sv/sapwm_pkg.sv
// Shared constants, codes and types of the servo angle to PWM level block.
package sapwm_pkg;

	localparam int NUM_SERVOS        = 3;
	localparam int DEFAULT_ANGLE_MAX = 18000;
	localparam int DEFAULT_PULSE_MIN = 1000;
	localparam int DEFAULT_PULSE_MAX = 2000;
	localparam int PULSE_FLOOR       = 500;
	localparam int PULSE_CEIL        = 2500;
	localparam int ANGLE_MIN_UNSET   = 0;
	localparam int FRAME_US          = 10000;
	localparam int LEVEL_MAX         = 65535;

	// field widths
	localparam int KIND_W  = 2;
	localparam int CH_W    = 2;
	localparam int ANGLE_W = 16;
	localparam int LEVEL_W = 16;
	localparam int CNT_W   = 2;
	localparam int IDX_W   = 2;
	localparam int SET_W   = 63;
	localparam int ACT_W   = 4;

	// datapath widths
	localparam int PULSE_W = 14;
	localparam int SPAN_W  = 16;
	localparam int PROD_W  = SPAN_W + PULSE_W;
	localparam int NUM_W   = PROD_W + 2;
	localparam int QUO_W   = 17;
	localparam int DVD_W   = NUM_W + 16;
	localparam int REM_W   = DVD_W - QUO_W;
	localparam int DIVC_W  = $clog2(QUO_W);

	// settings register layout
	localparam int AMIN_LSB      = 0;
	localparam int AMAX_LSB      = 16;
	localparam int PMIN_LSB      = 32;
	localparam int PMAX_LSB      = 46;
	localparam int SWAP_BIT      = 60;
	localparam int MIN_UNSET_BIT = 61;
	localparam int MAX_UNSET_BIT = 62;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SERVO_COUNT   = 2'd0;
	localparam int               REG_SETTINGS_BASE = 1;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENABLE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REFRESH = 2'd2;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_PREP,
		DP_MUL_A,
		DP_MUL_B,
		DP_MUL_D,
		DP_COMB,
		DP_DIV,
		DP_EMIT
	} dp_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D,
		ST_COMB,
		ST_DIV,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		dp_op_t          op;
		logic [CH_W-1:0] channel;
		logic            store_angle;
		logic            zero_level;
		logic            enabled;
		logic            last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

### sv/sapwm_cmd_if.sv
// Input channel: one command word per handshake.
interface sapwm_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [sapwm_pkg::KIND_W-1:0]      kind;
	logic [sapwm_pkg::CH_W-1:0]        servo_index;
	logic signed [sapwm_pkg::ANGLE_W-1:0] angle;
	logic                              enable_on;

	modport source (output valid, kind, servo_index, angle, enable_on, input ready);
	modport sink (input valid, kind, servo_index, angle, enable_on, output ready);
endinterface

### sv/sapwm_lvl_if.sv
// Output channel: one compare level word per handshake.
interface sapwm_lvl_if;
	logic                          valid;
	logic                          ready;
	logic [sapwm_pkg::CH_W-1:0]    channel;
	logic [sapwm_pkg::LEVEL_W-1:0] compare_level;
	logic                          outputs_enabled;
	logic                          last;

	modport source (output valid, channel, compare_level, outputs_enabled, last, input ready);
	modport sink (input valid, channel, compare_level, outputs_enabled, last, output ready);
endinterface

### sv/sapwm_ctrl.sv
// Controller: command decode, channel sequencing and datapath step control.
module sapwm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	sapwm_cmd_if.sink                     cmd,
	input  logic                          cfg_we,
	input  logic [sapwm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [sapwm_pkg::CNT_W-1:0]   cfg_count,
	input  sapwm_pkg::dp_status_t         status,
	output sapwm_pkg::dp_cmd_t            dp_cmd
);

	sapwm_pkg::ctl_state_t            state_q, state_d;
	logic [sapwm_pkg::CNT_W-1:0]      count_q;
	logic                             on_q, on_d;
	logic [sapwm_pkg::CH_W-1:0]       ch_q, ch_d;
	logic                             run_all_q, run_all_d;
	logic                             zero_q, zero_d;
	logic [sapwm_pkg::DIVC_W-1:0]     div_cnt_q, div_cnt_d;
	logic [sapwm_pkg::ACT_W-1:0]      active;
	logic                             ch_last;
	logic                             en_req;

	assign active = ({2'b00, count_q} < sapwm_pkg::ACT_W'(sapwm_pkg::NUM_SERVOS))
		? {2'b00, count_q} : sapwm_pkg::ACT_W'(sapwm_pkg::NUM_SERVOS);
	assign ch_last = ({2'b00, ch_q} + 4'd1) == active;
	assign en_req  = cmd.enable_on && (active != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sapwm_pkg::ST_IDLE;
			count_q   <= 2'd3;
			on_q      <= 1'b0;
			ch_q      <= '0;
			run_all_q <= 1'b0;
			zero_q    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			on_q      <= on_d;
			ch_q      <= ch_d;
			run_all_q <= run_all_d;
			zero_q    <= zero_d;
			div_cnt_q <= div_cnt_d;
			if (cfg_we && cfg_index == sapwm_pkg::REG_SERVO_COUNT) begin
				count_q <= cfg_count;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		on_d      = on_q;
		ch_d      = ch_q;
		run_all_d = run_all_q;
		zero_d    = zero_q;
		div_cnt_d = div_cnt_q;
		cmd.ready = 1'b0;
		dp_cmd.op          = sapwm_pkg::DP_NOP;
		dp_cmd.channel     = ch_q;
		dp_cmd.store_angle = 1'b0;
		dp_cmd.zero_level  = zero_q;
		dp_cmd.enabled     = on_q;
		dp_cmd.last        = !run_all_q || ch_last;

		unique case (state_q)
			sapwm_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					case (cmd.kind)
						sapwm_pkg::KIND_WRITE: begin
							if ({2'b00, cmd.servo_index} < active) begin
								dp_cmd.store_angle = 1'b1;
								dp_cmd.channel     = cmd.servo_index;
								if (on_q) begin
									ch_d      = cmd.servo_index;
									run_all_d = 1'b0;
									zero_d    = 1'b0;
									state_d   = sapwm_pkg::ST_PREP;
								end
							end
						end
						sapwm_pkg::KIND_ENABLE: begin
							on_d = en_req;
							if (active != '0) begin
								ch_d      = '0;
								run_all_d = 1'b1;
								zero_d    = !en_req;
								state_d   = en_req ? sapwm_pkg::ST_PREP : sapwm_pkg::ST_EMIT;
							end
						end
						sapwm_pkg::KIND_REFRESH: begin
							if (on_q && active != '0) begin
								ch_d      = '0;
								run_all_d = 1'b1;
								zero_d    = 1'b0;
								state_d   = sapwm_pkg::ST_PREP;
							end
						end
						default: begin
							// unknown kind: drop
						end
					endcase
				end
			end
			sapwm_pkg::ST_PREP: begin
				dp_cmd.op = sapwm_pkg::DP_PREP;
				state_d   = sapwm_pkg::ST_MUL_A;
			end
			sapwm_pkg::ST_MUL_A: begin
				dp_cmd.op = sapwm_pkg::DP_MUL_A;
				state_d   = sapwm_pkg::ST_MUL_B;
			end
			sapwm_pkg::ST_MUL_B: begin
				dp_cmd.op = sapwm_pkg::DP_MUL_B;
				state_d   = sapwm_pkg::ST_MUL_D;
			end
			sapwm_pkg::ST_MUL_D: begin
				dp_cmd.op = sapwm_pkg::DP_MUL_D;
				state_d   = sapwm_pkg::ST_COMB;
			end
			sapwm_pkg::ST_COMB: begin
				dp_cmd.op = sapwm_pkg::DP_COMB;
				div_cnt_d = '0;
				state_d   = sapwm_pkg::ST_DIV;
			end
			sapwm_pkg::ST_DIV: begin
				dp_cmd.op = sapwm_pkg::DP_DIV;
				div_cnt_d = div_cnt_q + 1'b1;
				if (div_cnt_q == sapwm_pkg::DIVC_W'(sapwm_pkg::QUO_W - 1)) begin
					state_d = sapwm_pkg::ST_EMIT;
				end
			end
			sapwm_pkg::ST_EMIT: begin
				// hold until the output register can take the word
				if (status.out_free) begin
					dp_cmd.op = sapwm_pkg::DP_EMIT;
					if (!run_all_q || ch_last) begin
						state_d = sapwm_pkg::ST_IDLE;
					end else begin
						ch_d    = ch_q + 1'b1;
						state_d = zero_q ? sapwm_pkg::ST_EMIT : sapwm_pkg::ST_PREP;
					end
				end
			end
			default: begin
				state_d = sapwm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### sv/sapwm_dp.sv
// Datapath: settings and angle storage, level arithmetic and output register.
module sapwm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sapwm_pkg::IDX_W-1:0]          cfg_index,
	input  logic [sapwm_pkg::SET_W-1:0]          cfg_data,
	input  logic signed [sapwm_pkg::ANGLE_W-1:0] angle,
	input  sapwm_pkg::dp_cmd_t                   dp_cmd,
	output sapwm_pkg::dp_status_t                status,
	sapwm_lvl_if.source                          lvl
);

	logic [sapwm_pkg::SET_W-1:0]          settings_q   [sapwm_pkg::NUM_SERVOS];
	logic signed [sapwm_pkg::ANGLE_W-1:0] last_angle_q [sapwm_pkg::NUM_SERVOS];

	// prep stage
	logic [sapwm_pkg::SET_W-1:0]          r;
	logic signed [sapwm_pkg::ANGLE_W-1:0] a, mn_raw, mx_raw, mn, mx, ac;
	logic signed [sapwm_pkg::ANGLE_W:0]   span_w, pos_w;
	logic [sapwm_pkg::PULSE_W-1:0]        pmin_r, pmax_r, pmin, pmax;
	logic                                 bad_pulse;
	logic [sapwm_pkg::SPAN_W-1:0]         span, pos;

	logic [sapwm_pkg::SPAN_W-1:0]  span_q, pos_q;
	logic [sapwm_pkg::PULSE_W-1:0] base_q, diff_q;
	logic                          swap_q;

	// shared multiplier
	logic [sapwm_pkg::SPAN_W-1:0]  mul_x;
	logic [sapwm_pkg::PULSE_W-1:0] mul_y;
	logic [sapwm_pkg::PROD_W-1:0]  product;
	logic [sapwm_pkg::PROD_W-1:0]  prod_a_q, prod_b_q, den_q;

	// combine and divide
	logic signed [sapwm_pkg::NUM_W-1:0] num;
	logic [sapwm_pkg::DVD_W-1:0]        dividend;
	logic                               nonpos_q;
	logic [sapwm_pkg::REM_W-1:0]        rem_q;
	logic [sapwm_pkg::QUO_W-1:0]        low_q;
	logic [sapwm_pkg::REM_W:0]          trial;
	logic [sapwm_pkg::REM_W:0]          den_x;
	logic                               ge;
	logic [sapwm_pkg::REM_W-1:0]        rem_next;
	logic [sapwm_pkg::LEVEL_W-1:0]      level;

	logic                              out_valid_q;
	logic [sapwm_pkg::CH_W-1:0]        out_ch_q;
	logic [sapwm_pkg::LEVEL_W-1:0]     out_level_q;
	logic                              out_en_q;
	logic                              out_last_q;

	for (genvar s = 0; s < sapwm_pkg::NUM_SERVOS; s++) begin : g_store
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				settings_q[s]   <= '0;
				last_angle_q[s] <= '0;
			end else begin
				if (cfg_we && int'(cfg_index) == sapwm_pkg::REG_SETTINGS_BASE + s) begin
					settings_q[s] <= cfg_data;
				end
				if (dp_cmd.store_angle && int'(dp_cmd.channel) == s) begin
					last_angle_q[s] <= angle;
				end
			end
		end
	end

	always_comb begin
		r      = settings_q[dp_cmd.channel];
		a      = last_angle_q[dp_cmd.channel];
		mn_raw = r[sapwm_pkg::MIN_UNSET_BIT] ? sapwm_pkg::ANGLE_W'(sapwm_pkg::ANGLE_MIN_UNSET)
			: signed'(r[sapwm_pkg::AMIN_LSB +: sapwm_pkg::ANGLE_W]);
		mx_raw = r[sapwm_pkg::MAX_UNSET_BIT] ? sapwm_pkg::ANGLE_W'(sapwm_pkg::DEFAULT_ANGLE_MAX)
			: signed'(r[sapwm_pkg::AMAX_LSB +: sapwm_pkg::ANGLE_W]);
		// swap reversed limits
		mn = (mx_raw < mn_raw) ? mx_raw : mn_raw;
		mx = (mx_raw < mn_raw) ? mn_raw : mx_raw;
		ac = (a < mn) ? mn : ((a > mx) ? mx : a);
		pmin_r = r[sapwm_pkg::PMIN_LSB +: sapwm_pkg::PULSE_W];
		pmax_r = r[sapwm_pkg::PMAX_LSB +: sapwm_pkg::PULSE_W];
		bad_pulse = (pmin_r < sapwm_pkg::PULSE_W'(sapwm_pkg::PULSE_FLOOR))
			|| (pmax_r > sapwm_pkg::PULSE_W'(sapwm_pkg::PULSE_CEIL))
			|| (pmin_r >= pmax_r);
		pmin = bad_pulse ? sapwm_pkg::PULSE_W'(sapwm_pkg::DEFAULT_PULSE_MIN) : pmin_r;
		pmax = bad_pulse ? sapwm_pkg::PULSE_W'(sapwm_pkg::DEFAULT_PULSE_MAX) : pmax_r;
		span_w = (sapwm_pkg::ANGLE_W + 1)'(mx) - (sapwm_pkg::ANGLE_W + 1)'(mn);
		pos_w  = (sapwm_pkg::ANGLE_W + 1)'(ac) - (sapwm_pkg::ANGLE_W + 1)'(mn);
		span   = span_w[sapwm_pkg::SPAN_W-1:0];
		pos    = pos_w[sapwm_pkg::SPAN_W-1:0];
		// equal limits map every angle to the start of the range
		if (span == '0) begin
			span = sapwm_pkg::SPAN_W'(1);
			pos  = '0;
		end
	end

	always_comb begin
		unique case (dp_cmd.op)
			sapwm_pkg::DP_MUL_A: begin
				mul_x = span_q;
				mul_y = base_q;
			end
			sapwm_pkg::DP_MUL_B: begin
				mul_x = pos_q;
				mul_y = diff_q;
			end
			default: begin
				mul_x = span_q;
				mul_y = sapwm_pkg::PULSE_W'(sapwm_pkg::FRAME_US);
			end
		endcase
		product = sapwm_pkg::PROD_W'(mul_x) * sapwm_pkg::PROD_W'(mul_y);
	end

	always_comb begin
		if (swap_q) begin
			num = sapwm_pkg::NUM_W'(prod_a_q) - sapwm_pkg::NUM_W'(prod_b_q);
		end else begin
			num = sapwm_pkg::NUM_W'(prod_a_q) + sapwm_pkg::NUM_W'(prod_b_q);
		end
		// round to nearest: add half the divisor
		dividend = {num, 16'd0}
			+ sapwm_pkg::DVD_W'(den_q >> 1);
		trial    = {rem_q, low_q[sapwm_pkg::QUO_W-1]};
		den_x    = (sapwm_pkg::REM_W + 1)'(den_q);
		ge       = trial >= den_x;
		rem_next = ge ? sapwm_pkg::REM_W'(trial - den_x) : trial[sapwm_pkg::REM_W-1:0];
		if (dp_cmd.zero_level || nonpos_q) begin
			level = '0;
		end else if (low_q > sapwm_pkg::QUO_W'(sapwm_pkg::LEVEL_MAX)) begin
			level = sapwm_pkg::LEVEL_W'(sapwm_pkg::LEVEL_MAX);
		end else begin
			level = low_q[sapwm_pkg::LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (dp_cmd.op)
			sapwm_pkg::DP_PREP: begin
				span_q <= span;
				pos_q  <= pos;
				diff_q <= pmax - pmin;
				base_q <= r[sapwm_pkg::SWAP_BIT] ? pmax : pmin;
				swap_q <= r[sapwm_pkg::SWAP_BIT];
			end
			sapwm_pkg::DP_MUL_A: prod_a_q <= product;
			sapwm_pkg::DP_MUL_B: prod_b_q <= product;
			sapwm_pkg::DP_MUL_D: den_q <= product;
			sapwm_pkg::DP_COMB: begin
				nonpos_q <= num[sapwm_pkg::NUM_W-1] || (num == '0);
				rem_q    <= dividend[sapwm_pkg::DVD_W-1:sapwm_pkg::QUO_W];
				low_q    <= dividend[sapwm_pkg::QUO_W-1:0];
			end
			sapwm_pkg::DP_DIV: begin
				rem_q <= rem_next;
				low_q <= {low_q[sapwm_pkg::QUO_W-2:0], ge};
			end
			sapwm_pkg::DP_EMIT: begin
				out_ch_q    <= dp_cmd.channel;
				out_level_q <= level;
				out_en_q    <= dp_cmd.enabled;
				out_last_q  <= dp_cmd.last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.op == sapwm_pkg::DP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (lvl.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free    = !out_valid_q || lvl.ready;
	assign lvl.valid          = out_valid_q;
	assign lvl.channel        = out_ch_q;
	assign lvl.compare_level  = out_level_q;
	assign lvl.outputs_enabled = out_en_q;
	assign lvl.last           = out_last_q;

endmodule

### sv/servo_angle_to_pwm_level.sv
// Servo angle to PWM compare level: top level.
//
// cmd carries one command word per handshake: an angle write for one servo,
// an outputs on/off request, or a refresh of all active servos. lvl carries
// compare level words (channel, level, outputs flag, last marker); a command
// yields zero to three words, last set on the final one.
// Configuration (servo count, per-servo settings) is written through cfg_we /
// cfg_index / cfg_data while the block is idle; the user must keep to this, the block does not check it.
// Each computed level passes, in order: limit and pulse-range decode, the
// products on the shared 16x14 multiplier, a combine step, the radix-2
// restoring divider for a 17-bit quotient, then the output register. An off
// request emits its zero levels one per cycle while lvl is ready.
// A new command is taken once the previous one has queued its last word, so
// the last word may still wait in the output register. If lvl stalls, the
// controller holds at the emit step and cmd stays not ready.
// Reset clears outputs-on, all stored angles and settings, sets the servo
// count to three and empties the output register.
module servo_angle_to_pwm_level (
	input  logic                          clk,
	input  logic                          arst_n,
	sapwm_cmd_if.sink                     cmd,
	sapwm_lvl_if.source                   lvl,
	input  logic                          cfg_we,
	input  logic [sapwm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [sapwm_pkg::SET_W-1:0]   cfg_data
);

	`include "servo_angle_to_pwm_level_assert.svh"

	sapwm_pkg::dp_cmd_t    dp_cmd;
	sapwm_pkg::dp_status_t status;

	sapwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_count (cfg_data[sapwm_pkg::CNT_W-1:0]),
		.status    (status),
		.dp_cmd    (dp_cmd)
	);

	sapwm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.angle     (cmd.angle),
		.dp_cmd    (dp_cmd),
		.status    (status),
		.lvl       (lvl)
	);

	`SAPWM_ASSERT_IMPLY(a_off_is_zero, lvl.valid && !lvl.outputs_enabled, lvl.compare_level == '0, "level must be zero while outputs are off")
	`SAPWM_ASSERT_IMPLY(a_channel_range, lvl.valid, int'(lvl.channel) < sapwm_pkg::NUM_SERVOS, "channel beyond servo count")
	`SAPWM_ASSERT_NEXT(a_emit_loads, dp_cmd.op == sapwm_pkg::DP_EMIT, lvl.valid, "emitted word not presented")

endmodule

### bench/testbench.sv
// Self-checking testbench for servo_angle_to_pwm_level, with a compare level predictor.
`timescale 1ns / 1ps

module testbench;
	import sapwm_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RUN_LIMIT    = 300000;
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASE_ITEMS  = 20;
	localparam int REPORT_MAX   = 10;

	localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
	localparam logic [SET_W-1:0]  SETTINGS_ONES = {SET_W{1'b1}};

	typedef struct {
		logic [KIND_W-1:0]         kind;
		logic [CH_W-1:0]           servo_index;
		logic signed [ANGLE_W-1:0] angle;
		logic                      enable_on;
	} servo_cmd_t;

	typedef struct {
		logic [CH_W-1:0]    channel;
		logic [LEVEL_W-1:0] level;
		logic               enabled;
		logic               last;
	} level_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [SET_W-1:0] cfg_data;

	sapwm_cmd_if cmd_ch ();
	sapwm_lvl_if lvl_ch ();

	servo_angle_to_pwm_level u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.lvl       (lvl_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [CNT_W-1:0]          shadow_count;
	logic [SET_W-1:0]          shadow_settings [NUM_SERVOS];
	logic signed [ANGLE_W-1:0] held_angle [NUM_SERVOS];
	logic                      shadow_on;

	servo_cmd_t  cmd_backlog [$];
	level_word_t expected_levels [$];

	servo_cmd_t  seen_cmd;
	level_word_t got_word;
	level_word_t want_word;
	logic        cmd_fire;

	int mismatches;
	int n_cmds;
	int n_levels;
	int n_reg_writes;
	int cycle_count;

	int gap_left;
	int burst_left;
	int rx_tick;
	int hold_left;
	int seg_left;
	int seg_mode;
	bit rx_ready_next;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int unsigned active_servos();
		return (shadow_count < NUM_SERVOS) ? shadow_count : NUM_SERVOS;
	endfunction

	function automatic logic [LEVEL_W-1:0] level_for_angle(int unsigned s,
			logic signed [ANGLE_W-1:0] a_cmd);
		logic [SET_W-1:0] r;
		logic signed [ANGLE_W-1:0] lo_field;
		logic signed [ANGLE_W-1:0] hi_field;
		longint mn, mx, pmin, pmax, a, span, pos, num, den, q, tmp;
		bit rev;
		r = shadow_settings[s];
		lo_field = r[AMIN_LSB +: ANGLE_W];
		hi_field = r[AMAX_LSB +: ANGLE_W];
		mn = r[MIN_UNSET_BIT] ? longint'(ANGLE_MIN_UNSET) : longint'(lo_field);
		mx = r[MAX_UNSET_BIT] ? longint'(DEFAULT_ANGLE_MAX) : longint'(hi_field);
		pmin = longint'(r[PMIN_LSB +: PULSE_W]);
		pmax = longint'(r[PMAX_LSB +: PULSE_W]);
		rev = r[SWAP_BIT];
		if (mx < mn) begin
			tmp = mn;
			mn = mx;
			mx = tmp;
		end
		a = longint'(a_cmd);
		if (a < mn) a = mn;
		if (a > mx) a = mx;
		if (pmin < PULSE_FLOOR || pmax > PULSE_CEIL || pmin >= pmax) begin
			pmin = DEFAULT_PULSE_MIN;
			pmax = DEFAULT_PULSE_MAX;
		end
		span = mx - mn;
		pos = a - mn;
		if (span <= 0) begin
			span = 1;
			pos = 0;
		end
		if (rev)
			num = pmax * span - pos * (pmax - pmin);
		else
			num = pmin * span + pos * (pmax - pmin);
		if (num <= 0)
			return '0;
		den = span * FRAME_US;
		// round half up: (2*num*65536 + den) / (2*den)
		q = (num * 131072 + den) / (den * 2);
		if (q > LEVEL_MAX)
			q = LEVEL_MAX;
		return q[LEVEL_W-1:0];
	endfunction

	task automatic push_level(int unsigned ch, logic [LEVEL_W-1:0] lvl_val, logic is_last);
		level_word_t w;
		w.channel = ch[CH_W-1:0];
		w.level   = lvl_val;
		w.enabled = shadow_on;
		w.last    = is_last;
		expected_levels.push_back(w);
	endtask

	task automatic push_all_levels();
		int unsigned n;
		n = active_servos();
		for (int unsigned s = 0; s < n; s++)
			push_level(s, shadow_on ? level_for_angle(s, held_angle[s]) : '0, s == n - 1);
	endtask

	task automatic apply_command(servo_cmd_t c);
		case (c.kind)
			KIND_WRITE: begin
				if (c.servo_index < active_servos()) begin
					held_angle[c.servo_index] = c.angle;
					if (shadow_on)
						push_level(c.servo_index, level_for_angle(c.servo_index, c.angle), 1'b1);
				end
			end
			KIND_ENABLE: begin
				shadow_on = c.enable_on && active_servos() > 0;
				push_all_levels();
			end
			KIND_REFRESH: begin
				if (shadow_on)
					push_all_levels();
			end
			default: ;
		endcase
	endtask

	task automatic store_reg(logic [IDX_W-1:0] idx, logic [SET_W-1:0] data);
		if (idx == REG_SERVO_COUNT)
			shadow_count = data[CNT_W-1:0];
		else if (idx - REG_SETTINGS_BASE < NUM_SERVOS)
			shadow_settings[idx - REG_SETTINGS_BASE] = data;
	endtask

	// write count and all settings back to back, then drop the enable
	task automatic program_regs(logic [CNT_W-1:0] count, logic [SET_W-1:0] s0,
			logic [SET_W-1:0] s1, logic [SET_W-1:0] s2);
		logic [SET_W-1:0] vals [4];
		vals[0] = SET_W'(count);
		vals[1] = s0;
		vals[2] = s1;
		vals[3] = s2;
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data  <= vals[i];
			store_reg(IDX_W'(i), vals[i]);
			n_reg_writes++;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SET_W-1:0] pack_settings(int amin, int amax, int pmin, int pmax,
			bit rev, bit min_unset, bit max_unset);
		logic [SET_W-1:0] r;
		r = '0;
		r[AMIN_LSB +: ANGLE_W] = amin[ANGLE_W-1:0];
		r[AMAX_LSB +: ANGLE_W] = amax[ANGLE_W-1:0];
		r[PMIN_LSB +: PULSE_W] = pmin[PULSE_W-1:0];
		r[PMAX_LSB +: PULSE_W] = pmax[PULSE_W-1:0];
		r[SWAP_BIT]      = rev;
		r[MIN_UNSET_BIT] = min_unset;
		r[MAX_UNSET_BIT] = max_unset;
		return r;
	endfunction

	function automatic logic [SET_W-1:0] random_settings();
		int amin, amax, pmin, pmax;
		if ($urandom_range(0, 1)) begin
			amin = $urandom_range(0, 9000);
			amax = $urandom_range(9000, 18000);
			if ($urandom_range(0, 3) == 0) begin
				amin = amax;
				amax = $urandom_range(0, 9000);
			end
		end else begin
			amin = $urandom;
			amax = $urandom;
		end
		if ($urandom_range(0, 9) < 7) begin
			pmin = $urandom_range(PULSE_FLOOR, 1500);
			pmax = $urandom_range(1500, PULSE_CEIL);
		end else begin
			pmin = $urandom;
			pmax = $urandom;
		end
		return pack_settings(amin, amax, pmin, pmax, $urandom_range(0, 1),
			$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
	endfunction

	task automatic queue_cmd(logic [KIND_W-1:0] kind, int idx, int ang, bit on);
		servo_cmd_t c;
		c.kind        = kind;
		c.servo_index = idx[CH_W-1:0];
		c.angle       = ang[ANGLE_W-1:0];
		c.enable_on   = on;
		cmd_backlog.push_back(c);
	endtask

	function automatic int random_angle();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return DEFAULT_ANGLE_MAX;
				endcase
			end
			default: return $urandom_range(0, DEFAULT_ANGLE_MAX);
		endcase
	endfunction

	// open with outputs on, then mostly angle writes with some refresh and on/off traffic
	task automatic queue_random(int n);
		int pick;
		queue_cmd(KIND_ENABLE, $urandom_range(0, 3), $urandom, 1'b1);
		for (int i = 1; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				queue_cmd(KIND_WRITE, $urandom_range(0, 3), random_angle(), $urandom_range(0, 1));
			else if (pick < 80)
				queue_cmd(KIND_REFRESH, $urandom_range(0, 3), $urandom, $urandom_range(0, 1));
			else if (pick < 95)
				queue_cmd(KIND_ENABLE, $urandom_range(0, 3), $urandom, $urandom_range(0, 4) != 0);
			else
				queue_cmd(KIND_UNUSED, $urandom_range(0, 3), $urandom, $urandom_range(0, 1));
		end
	endtask

	// hold until every word has come back and the block has gone quiet
	task automatic wait_idle();
		while (cmd_backlog.size() > 0 || expected_levels.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of words with random gaps between them
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!(cmd_ch.valid && !cmd_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_ch.valid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				cmd_ch.valid       <= 1'b1;
				cmd_ch.kind        <= cmd_backlog[0].kind;
				cmd_ch.servo_index <= cmd_backlog[0].servo_index;
				cmd_ch.angle       <= cmd_backlog[0].angle;
				cmd_ch.enable_on   <= cmd_backlog[0].enable_on;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 10);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: segments of steady, random and sparse ready, with a long hold now and then
	always @(negedge clk) begin
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			rx_ready_next = 1'b0;
		end else if (rx_tick % 1500 == 700) begin
			hold_left = 250;
			rx_ready_next = 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 2);
				seg_left = $urandom_range(10, 60);
			end
			seg_left--;
			case (seg_mode)
				0: rx_ready_next = 1'b1;
				1: rx_ready_next = $urandom_range(0, 1);
				default: rx_ready_next = ($urandom_range(0, 3) == 0);
			endcase
		end
		lvl_ch.ready <= rx_ready_next;
	end

	always @(posedge clk) begin
		cmd_fire <= arst_n && cmd_ch.valid && cmd_ch.ready;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			seen_cmd.kind        = cmd_ch.kind;
			seen_cmd.servo_index = cmd_ch.servo_index;
			seen_cmd.angle       = cmd_ch.angle;
			seen_cmd.enable_on   = cmd_ch.enable_on;
			void'(cmd_backlog.pop_front());
			apply_command(seen_cmd);
			n_cmds++;
		end
		if (arst_n && lvl_ch.valid && lvl_ch.ready) begin
			got_word.channel = lvl_ch.channel;
			got_word.level   = lvl_ch.compare_level;
			got_word.enabled = lvl_ch.outputs_enabled;
			got_word.last    = lvl_ch.last;
			n_levels++;
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected level word ch=%0d level=%0d on=%0b last=%0b",
						$realtime, got_word.channel, got_word.level, got_word.enabled,
						got_word.last);
			end else begin
				want_word = expected_levels.pop_front();
				if (got_word.channel !== want_word.channel || got_word.level !== want_word.level ||
						got_word.enabled !== want_word.enabled ||
						got_word.last !== want_word.last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: level word exp ch=%0d lvl=%0d on=%0b last=%0b got ch=%0d lvl=%0d on=%0b last=%0b",
							$realtime, want_word.channel, want_word.level, want_word.enabled,
							want_word.last, got_word.channel, got_word.level,
							got_word.enabled, got_word.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("run stalled at %0d cycles, %0d level words still owed",
				cycle_count, expected_levels.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.kind        = KIND_WRITE;
		cmd_ch.servo_index = '0;
		cmd_ch.angle       = '0;
		cmd_ch.enable_on   = 1'b0;
		lvl_ch.ready       = 1'b0;
		cmd_fire           = 1'b0;
		mismatches         = 0;
		n_cmds             = 0;
		n_levels           = 0;
		n_reg_writes       = 0;
		cycle_count        = 0;
		gap_left           = 0;
		burst_left         = 0;
		rx_tick            = 0;
		hold_left          = 0;
		seg_left           = 0;
		seg_mode           = 0;
		shadow_count       = CNT_W'(NUM_SERVOS);
		shadow_on          = 1'b0;
		for (int s = 0; s < NUM_SERVOS; s++) begin
			shadow_settings[s] = '0;
			held_angle[s]      = '0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain servo, reversed limits with swap, and the all-zero reset settings
		program_regs(2'd3,
			pack_settings(0, DEFAULT_ANGLE_MAX, DEFAULT_PULSE_MIN, DEFAULT_PULSE_MAX, 0, 0, 0),
			pack_settings(12000, -4500, PULSE_FLOOR, PULSE_CEIL, 1, 0, 0),
			'0);
		queue_cmd(KIND_WRITE, 0, 9000, 1'b0);      // stored while off, no word
		queue_cmd(KIND_REFRESH, 0, 0, 1'b1);       // refresh while off
		queue_cmd(KIND_ENABLE, 0, 0, 1'b1);
		queue_cmd(KIND_WRITE, 0, -32768, 1'b0);
		queue_cmd(KIND_WRITE, 0, 32767, 1'b0);
		queue_cmd(KIND_WRITE, 0, 9000, 1'b1);
		queue_cmd(KIND_WRITE, 1, 0, 1'b0);
		queue_cmd(KIND_WRITE, 1, 32767, 1'b0);
		queue_cmd(KIND_WRITE, 1, -32768, 1'b1);
		queue_cmd(KIND_WRITE, 2, 1234, 1'b0);      // zero span
		queue_cmd(KIND_WRITE, 3, 100, 1'b0);       // inactive servo
		queue_cmd(KIND_UNUSED, 1, -1, 1'b1);
		queue_cmd(KIND_REFRESH, 2, 0, 1'b0);
		queue_cmd(KIND_ENABLE, 0, 0, 1'b0);        // zeros for every servo
		queue_cmd(KIND_WRITE, 1, 4000, 1'b0);
		queue_cmd(KIND_ENABLE, 3, 16'h7fff, 1'b1);
		queue_cmd(KIND_ENABLE, 2, 16'h5555, 1'b1);
		queue_cmd(KIND_WRITE, 0, 16'h5555, 1'b1);
		queue_cmd(KIND_WRITE, 0, -21846, 1'b0);
		wait_idle();

		// no active servos: nothing comes out
		program_regs(2'd0, SETTINGS_ONES, random_settings(), random_settings());
		queue_cmd(KIND_ENABLE, 0, 0, 1'b1);
		queue_cmd(KIND_WRITE, 0, 500, 1'b1);
		queue_cmd(KIND_REFRESH, 0, 0, 1'b1);
		queue_cmd(KIND_ENABLE, 1, 0, 1'b0);
		wait_idle();

		program_regs(2'd3, random_settings(), random_settings(), SETTINGS_ONES);
		queue_random(PHASE_ITEMS);
		wait_idle();

		program_regs(2'd2, random_settings(), random_settings(), random_settings());
		queue_random(PHASE_ITEMS);
		wait_idle();

		program_regs(2'd1, random_settings(), '0, random_settings());
		queue_random(PHASE_ITEMS);
		wait_idle();

		program_regs(2'd3, random_settings(), random_settings(), random_settings());
		queue_random(PHASE_ITEMS);
		wait_idle();

		$display("covered %0d commands over %0d register writes (servo counts 0 to 3)",
			n_cmds, n_reg_writes);
		$display("checked %0d compare level words, %0d mismatched", n_levels, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/sapwm_pkg.sv
sv/sapwm_cmd_if.sv
sv/sapwm_lvl_if.sv
sv/sapwm_ctrl.sv
sv/sapwm_dp.sv
sv/servo_angle_to_pwm_level.sv
bench/testbench.sv
